[rtl/pmst_pkg.sv]
// Package: shared types and constants for the Prim spanning tree block.
`timescale 1ns / 1ps
package pmst_pkg;

  localparam int unsigned NV    = 16;            // vertex slots, fixed by 4-bit ids
  localparam int unsigned VW    = 4;             // vertex id width
  localparam int unsigned MW    = 2 * VW;        // matrix address width
  localparam int unsigned WW    = 16;            // weight width
  localparam int unsigned CW    = 20;            // total cost width

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_ADD_WR2,
    ST_RUN,
    ST_EMIT,
    ST_SUMM
  } state_t;

  // One vertex record as it travels around the cell ring
  typedef struct packed {
    logic [WW-1:0] key;    // best key, signed
    logic          fin;    // key is finite
    logic          vis;    // vertex joined the tree
    logic          par_v;  // parent known
    logic [VW-1:0] par;    // parent vertex
  } rec_t;

endpackage

[rtl/prim_minimum_spanning_tree.sv]
// Top level: Prim minimum spanning tree over a 16-vertex weight matrix.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid/in_ready, func..start_vertex  | in
//  out     | out_valid/out_ready, is_total..last    | out
//  cfg     | cfg_we, cfg_data (vertex_count)        | in
//
// Add item: read, compare and write both halves. Clear: acts as it is taken.
// Run: one ring rotation of 16 cells per round, rounds until no vertex is
// left to reach, then a rotation to walk out the edges and then the
// summary.
// Reset is synchronous; presence bits clear at once, weights stay unknown.
// Output stalls hold the ring during the edge walk; input waits until idle.
`timescale 1ns / 1ps
module prim_minimum_spanning_tree (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [4:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [3:0]                    in_end_a,
  input  logic [3:0]                    in_end_b,
  input  logic signed [15:0]            in_weight,
  input  logic [3:0]                    in_start_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_total,
  output logic [3:0]                    out_parent_vertex,
  output logic [3:0]                    out_child_vertex,
  output logic signed [15:0]            out_edge_weight,
  output logic signed [19:0]            out_total_cost,
  output logic                          out_bad_source,
  output logic                          out_last
);

  localparam int unsigned NV = pmst_pkg::NV;
  localparam int unsigned VW = pmst_pkg::VW;
  localparam int unsigned MW = pmst_pkg::MW;
  localparam int unsigned WW = pmst_pkg::WW;
  localparam int unsigned CW = pmst_pkg::CW;

  pmst_pkg::state_t state_r, state_nxt;

  logic [4:0]    vc_r;
  logic [4:0]    n_eff;
  logic [VW-1:0] a_r, b_r;
  logic [WW-1:0] w_r;
  logic          upd_r;
  logic [NV-1:0] pres_r [NV];  // one row of presence bits per vertex
  logic          pres_q;
  logic [WW-1:0] rdata;
  logic          ram_we;
  logic [MW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] u_r, u_nxt;
  logic          u_v_r;
  logic          c_v_r;
  logic [WW-1:0] c_key_r;
  logic [VW-1:0] c_idx_r;
  logic [CW-1:0] cost_r;
  logic          bad_r;
  logic          ring_init, ring_step;
  logic          accept, out_free, add_upd;

  pmst_pkg::rec_t rec [NV];
  pmst_pkg::rec_t head_new;

  // run-round signals
  logic          active, mark, relax, cand_take, c_v_new, emit;
  logic [WW-1:0] c_key_new;
  logic [VW-1:0] c_idx_new;

  assign n_eff    = (vc_r > 5'(NV)) ? 5'(NV) : vc_r;
  assign in_ready = (state_r == pmst_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign add_upd  = !pres_r[a_r][b_r] || ($signed(w_r) < $signed(rdata));

  // weight matrix
  pmst_ram #(.WIDTH(WW), .DEPTH(NV*NV)) u_wmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (w_r),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // ring of vertex cells, head is cell 0; loaded as the run item is taken
  for (genvar i = 0; i < NV; i++) begin : g_cell
    pmst_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .init  (ring_init),
      .shift (ring_step),
      .src   (in_start_vertex),
      .shin  ((i == NV - 1) ? head_new : rec[(i + 1) % NV]),
      .rec   (rec[i])
    );
  end

  // head unit: visit mark, relaxation and running minimum
  always_comb begin
    active    = ({1'b0, cnt_r} < n_eff);
    head_new  = rec[0];
    mark      = (state_r == pmst_pkg::ST_RUN) && u_v_r && (cnt_r == u_r);
    if (mark) begin
      head_new.vis = 1'b1;
    end
    relax = (state_r == pmst_pkg::ST_RUN) && active && u_v_r && !head_new.vis && pres_q &&
            (!rec[0].fin || ($signed(rdata) < $signed(rec[0].key)));
    if (relax) begin
      head_new.fin   = 1'b1;
      head_new.key   = rdata;
      head_new.par_v = 1'b1;
      head_new.par   = u_r;
    end
    cand_take = active && !head_new.vis && head_new.fin &&
                (!c_v_r || ($signed(head_new.key) < $signed(c_key_r)));
    c_v_new   = c_v_r || cand_take;
    c_key_new = cand_take ? head_new.key : c_key_r;
    c_idx_new = cand_take ? cnt_r : c_idx_r;
    emit      = active && rec[0].par_v;
  end

  // next state and control
  always_comb begin
    state_nxt = state_r;
    ring_init = 1'b0;
    ring_step = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {a_r, b_r};
    cnt_nxt   = cnt_r;
    u_nxt     = u_r;
    unique case (state_r)
      pmst_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            pmst_pkg::FUNC_ADD: begin
              if (in_end_a != in_end_b && {1'b0, in_end_a} < n_eff &&
                  {1'b0, in_end_b} < n_eff) begin
                state_nxt = pmst_pkg::ST_ADD_RD;
              end
            end
            pmst_pkg::FUNC_RUN: begin
              if ({1'b0, in_start_vertex} < n_eff) begin
                state_nxt = pmst_pkg::ST_RUN;
              end else begin
                state_nxt = pmst_pkg::ST_SUMM;
              end
            end
            default: ;
          endcase
        end
      end
      pmst_pkg::ST_ADD_RD: state_nxt = pmst_pkg::ST_ADD_WR;
      pmst_pkg::ST_ADD_WR: begin
        ram_we    = add_upd;
        state_nxt = pmst_pkg::ST_ADD_WR2;
      end
      pmst_pkg::ST_ADD_WR2: begin
        ram_we    = upd_r;
        ram_waddr = {b_r, a_r};
        state_nxt = pmst_pkg::ST_IDLE;
      end
      pmst_pkg::ST_RUN: begin
        ring_step = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == VW'(NV - 1)) begin
          u_nxt = c_idx_new;
          if (!c_v_new) begin
            state_nxt = pmst_pkg::ST_EMIT;
          end
        end
      end
      pmst_pkg::ST_EMIT: begin
        if (!emit || out_free) begin
          ring_step = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == VW'(NV - 1)) begin
            state_nxt = pmst_pkg::ST_SUMM;
          end
        end
      end
      pmst_pkg::ST_SUMM: begin
        if (out_free) begin
          state_nxt = pmst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pmst_pkg::ST_IDLE;
    endcase
    if (accept && in_func == pmst_pkg::FUNC_RUN) begin
      ring_init = 1'b1;
    end
    ram_raddr = (state_r == pmst_pkg::ST_RUN) ? {u_nxt, cnt_nxt} : {a_r, b_r};
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config register and presence bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 5'(NV);
      for (int i = 0; i < NV; i++) begin
        pres_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        vc_r <= cfg_data;
      end
      if (accept && in_func == pmst_pkg::FUNC_CLEAR) begin
        for (int i = 0; i < NV; i++) begin
          pres_r[i] <= '0;
        end
      end else if (state_r == pmst_pkg::ST_ADD_WR) begin
        pres_r[a_r][b_r] <= 1'b1;
        pres_r[b_r][a_r] <= 1'b1;
      end
    end
  end

  // run control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      u_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      cost_r  <= '0;
      bad_r   <= 1'b0;
    end else begin
      if (accept && in_func == pmst_pkg::FUNC_RUN) begin
        cnt_r  <= '0;
        u_v_r  <= 1'b0;
        c_v_r  <= 1'b0;
        cost_r <= '0;
        bad_r  <= !({1'b0, in_start_vertex} < n_eff);
      end else begin
        cnt_r <= cnt_nxt;
        if (state_r == pmst_pkg::ST_RUN) begin
          if (mark) begin
            cost_r <= cost_r + CW'($signed(rec[0].key));
          end
          if (cnt_r == VW'(NV - 1)) begin
            u_v_r <= c_v_new;
            c_v_r <= 1'b0;
          end else begin
            c_v_r <= c_v_new;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r   <= in_end_a;
      b_r   <= in_end_b;
      w_r   <= in_weight;
    end
    if (state_r == pmst_pkg::ST_ADD_WR) begin
      upd_r <= add_upd;
    end
    if (state_r == pmst_pkg::ST_RUN) begin
      u_r     <= u_nxt;
      c_key_r <= c_key_new;
      c_idx_r <= c_idx_new;
    end
    pres_q <= pres_r[ram_raddr[MW-1:VW]][ram_raddr[VW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == pmst_pkg::ST_EMIT && emit && out_free) begin
      out_valid <= 1'b1;
    end else if (state_r == pmst_pkg::ST_SUMM && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pmst_pkg::ST_EMIT && emit && out_free) begin
      out_is_total      <= 1'b0;
      out_parent_vertex <= rec[0].par;
      out_child_vertex  <= cnt_r;
      out_edge_weight   <= rec[0].key;
      out_total_cost    <= '0;
      out_bad_source    <= 1'b0;
      out_last          <= 1'b0;
    end else if (state_r == pmst_pkg::ST_SUMM && out_free) begin
      out_is_total      <= 1'b1;
      out_parent_vertex <= '0;
      out_child_vertex  <= '0;
      out_edge_weight   <= '0;
      out_total_cost    <= cost_r;
      out_bad_source    <= bad_r;
      out_last          <= 1'b1;
    end
  end

endmodule

[rtl/pmst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module pmst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pmst_cell.sv]
// One cell of the vertex ring: holds a record, loads its start value, shifts.
`timescale 1ns / 1ps
module pmst_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  logic                     init,
  input  logic                     shift,
  input  logic [pmst_pkg::VW-1:0]  src,
  input  pmst_pkg::rec_t           shin,
  output pmst_pkg::rec_t           rec
);

  pmst_pkg::rec_t rec_r;

  assign rec = rec_r;

  // start of run: infinite key except the source, nothing visited
  always_ff @(posedge clk) begin
    if (init) begin
      rec_r.key   <= '0;
      rec_r.fin   <= (src == IDX[pmst_pkg::VW-1:0]);
      rec_r.vis   <= 1'b0;
      rec_r.par_v <= 1'b0;
      rec_r.par   <= '0;
    end else if (shift) begin
      rec_r <= shin;
    end
  end

endmodule

[rtl/pmst_checker.sv]
// Port-level checker for the Prim spanning tree block, bound to the top.
`timescale 1ns / 1ps
module pmst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_is_total,
  input logic [3:0]         out_parent_vertex,
  input logic [3:0]         out_child_vertex,
  input logic signed [19:0] out_total_cost,
  input logic               out_bad_source,
  input logic               out_last
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the summary and only the summary closes a run
  a_last_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_is_total))
    else $error("last flag does not match summary");

  // bad source gives an empty tree
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_source |-> out_is_total && out_total_cost == 20'sd0)
    else $error("bad source summary carries cost");

  // tree edges never loop on one vertex and carry no cost or bad source flag
  a_no_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_total |-> out_parent_vertex != out_child_vertex &&
      !out_bad_source && out_total_cost == 20'sd0)
    else $error("malformed tree edge");

endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_is_total      (out_is_total),
  .out_parent_vertex (out_parent_vertex),
  .out_child_vertex  (out_child_vertex),
  .out_total_cost    (out_total_cost),
  .out_bad_source    (out_bad_source),
  .out_last          (out_last)
);
